FILE: design/sgm_pkg.sv
// shared types and constants for the sobel gradient magnitude block
`timescale 1ns / 1ps

package sgm_pkg;

    localparam int PIX_W = 8;
    localparam int SUM_W = PIX_W + 2;
    localparam int MAG_W = 11;
    localparam int CFG_W = 11;
    localparam int LS_W  = 2 * PIX_W;

    localparam logic [CFG_W-1:0] CFG_WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] CFG_HEIGHT_RESET = 11'd480;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = 2;
    localparam int OUT_CW    = 3;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic res;
        logic last;
    } t_stage_ctl;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             last;
    } t_result;

endpackage

FILE: design/sgm_line_store.sv
// line store memory holding the upper and middle rows per column
`timescale 1ns / 1ps

module sgm_line_store
    import sgm_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output logic [LS_W-1:0] o_rd_data,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  logic [LS_W-1:0] i_wr_data
);

    logic [LS_W-1:0] r_mem [DEPTH];
    logic [LS_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/sgm_window_kernel.sv
// 3x3 pixel window and sobel l1 magnitude
`timescale 1ns / 1ps

module sgm_window_kernel
    import sgm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_stage_ctl       i_ctl,
    input  logic [PIX_W-1:0] i_up,
    input  logic [PIX_W-1:0] i_mid,
    input  logic [PIX_W-1:0] i_px,
    output logic             o_res_valid,
    output t_result          o_result
);

    logic [PIX_W-1:0] r_win [9];
    logic [PIX_W-1:0] n_win [9];
    logic             r_res_valid;
    logic             r_res_last;

    logic [SUM_W-1:0] w_right;
    logic [SUM_W-1:0] w_left;
    logic [SUM_W-1:0] w_bottom;
    logic [SUM_W-1:0] w_top;
    logic [SUM_W-1:0] w_dx;
    logic [SUM_W-1:0] w_dy;

    // shift the window left by one column, new column on the right
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k*3+0] = r_win[k*3+1];
            n_win[k*3+1] = r_win[k*3+2];
        end
        n_win[2] = i_up;
        n_win[5] = i_mid;
        n_win[8] = i_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
            r_res_valid <= 1'b0;
            r_res_last  <= 1'b0;
        end else begin
            if (i_ctl.valid) begin
                for (int k = 0; k < 9; k++) begin
                    r_win[k] <= n_win[k];
                end
            end
            r_res_valid <= i_ctl.valid && i_ctl.res;
            r_res_last  <= i_ctl.last;
        end
    end

    always_comb begin
        w_right  = {2'b00, r_win[2]} + {1'b0, r_win[5], 1'b0} + {2'b00, r_win[8]};
        w_left   = {2'b00, r_win[0]} + {1'b0, r_win[3], 1'b0} + {2'b00, r_win[6]};
        w_bottom = {2'b00, r_win[6]} + {1'b0, r_win[7], 1'b0} + {2'b00, r_win[8]};
        w_top    = {2'b00, r_win[0]} + {1'b0, r_win[1], 1'b0} + {2'b00, r_win[2]};
        w_dx     = (w_right >= w_left) ? (w_right - w_left) : (w_left - w_right);
        w_dy     = (w_bottom >= w_top) ? (w_bottom - w_top) : (w_top - w_bottom);
    end

    assign o_res_valid        = r_res_valid;
    assign o_result.magnitude = {1'b0, w_dx} + {1'b0, w_dy};
    assign o_result.last      = r_res_last;

endmodule

FILE: design/sgm_out_fifo.sv
// small result queue between the kernel and the output channel
`timescale 1ns / 1ps

module sgm_out_fifo
    import sgm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_result           i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output t_result           o_data,
    output logic [OUT_CW-1:0] o_count
);

    t_result           r_mem [OUT_DEPTH];
    logic [OUT_AW-1:0] r_wptr;
    logic [OUT_AW-1:0] r_rptr;
    logic [OUT_CW-1:0] r_count;
    logic              w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + OUT_AW'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + OUT_AW'(1);
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + OUT_CW'(1);
                2'b01:   r_count <= r_count - OUT_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

FILE: design/sobel_gradient_magnitude.sv
// top level of the streaming 3x3 sobel edge detector with l1 magnitude
// usage:
//   input channel: i_valid / o_stall carry one 8-bit pixel per request in
//   raster order; a request is taken at an edge with i_valid high, o_stall low
//   output channel: o_valid / i_stall carry one magnitude per interior pixel,
//   with o_last_in_frame on the final interior result of the frame
//   configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 image width, 1 image height); the user must write only while the block
//   is idle, as the block itself does not enforce it
//   throughput: one pixel per cycle while o_stall is low; the line store
//   does one read at acceptance and one write-back in the following cycle,
//   so requests may follow back to back
//   reset: size returns to 640 x 480, counters, window and queue clear; line
//   store contents stay undefined until the first two rows are written
//   stall: a four-entry result queue absorbs results; o_stall rises once the
//   queue plus the two requests in flight would fill it
`timescale 1ns / 1ps

module sobel_gradient_magnitude
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [MAG_W-1:0] o_magnitude,
    output logic             o_last_in_frame,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CW1 = CW + 1;
    localparam int RW1 = RW + 1;

    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [CW-1:0]    n_col;
    logic [RW-1:0]    n_row;
    logic [CW1-1:0]   w_eff;
    logic [RW1-1:0]   h_eff;
    logic [CW1-1:0]   w_col_inc;
    logic [RW1-1:0]   w_row_inc;

    t_stage_ctl       r_s1;
    logic [CW-1:0]    r_s1_idx;
    logic [PIX_W-1:0] r_s1_px;
    t_stage_ctl       n_s1;

    logic             w_accept;
    logic [LS_W-1:0]  w_rd_data;
    logic             w_res_valid;
    t_result          w_result;
    t_result          w_head;
    logic [OUT_CW-1:0] w_fifo_count;
    logic [OUT_CW-1:0] w_credit;

    assign w_accept = i_valid && !o_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CFG_WIDTH_RESET;
            r_cfg_height <= CFG_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default:          r_cfg_width  <= r_cfg_width;
            endcase
        end
    end

    // saturate frame size to the supported range
    always_comb begin
        if (r_cfg_width < CFG_W'(3)) begin
            w_eff = CW1'(3);
        end else if (int'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = CW1'(MAX_WIDTH);
        end else begin
            w_eff = CW1'(r_cfg_width);
        end
        if (r_cfg_height < CFG_W'(3)) begin
            h_eff = RW1'(3);
        end else if (int'(r_cfg_height) > MAX_HEIGHT) begin
            h_eff = RW1'(MAX_HEIGHT);
        end else begin
            h_eff = RW1'(r_cfg_height);
        end
    end

    // raster counters and result flags for the pixel being taken
    always_comb begin
        w_col_inc = {1'b0, r_col} + CW1'(1);
        w_row_inc = {1'b0, r_row} + RW1'(1);
        if (w_col_inc >= w_eff) begin
            n_col = '0;
            n_row = (w_row_inc >= h_eff) ? '0 : w_row_inc[RW-1:0];
        end else begin
            n_col = w_col_inc[CW-1:0];
            n_row = r_row;
        end
        n_s1.valid = w_accept;
        n_s1.res   = (r_row >= RW'(2)) && (r_col >= CW'(2)) &&
                     ({1'b0, r_row} < h_eff) && ({1'b0, r_col} < w_eff);
        n_s1.last  = ({1'b0, r_row} == h_eff - RW1'(1)) &&
                     ({1'b0, r_col} == w_eff - CW1'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1  <= '0;
        end else begin
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_idx <= r_col;
            r_s1_px  <= i_pixel;
        end
    end

    // read at acceptance, write back the shifted column in the following cycle
    sgm_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_s1.valid),
        .i_wr_addr (r_s1_idx),
        .i_wr_data ({w_rd_data[PIX_W-1:0], r_s1_px})
    );

    sgm_window_kernel u_kernel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_s1),
        .i_up        (w_rd_data[LS_W-1:PIX_W]),
        .i_mid       (w_rd_data[PIX_W-1:0]),
        .i_px        (r_s1_px),
        .o_res_valid (w_res_valid),
        .o_result    (w_result)
    );

    sgm_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_result),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_data  (w_head),
        .o_count (w_fifo_count)
    );

    // queue entries plus requests still in flight
    assign w_credit = w_fifo_count + OUT_CW'(r_s1.valid) + OUT_CW'(w_res_valid);
    assign o_stall  = (w_credit >= OUT_CW'(OUT_DEPTH));

    assign o_magnitude     = w_head.magnitude;
    assign o_last_in_frame = w_head.last;

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_credit <= OUT_CW'(OUT_DEPTH))
        else $error("result queue credit overrun");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1.valid)
        else $error("accepted request missing from first stage");

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_col_inc >= w_eff)) |=> (r_col == '0))
        else $error("column counter failed to wrap");

    a_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid |-> (r_s1_idx == $past(r_col)))
        else $error("line store write-back address mismatch");

endmodule
